### hdl/bbc_pkg.sv
`default_nettype none
package bbc_pkg;

  // request actions
  localparam logic [1:0] ACT_GET     = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_PIN     = 2'd2;
  localparam logic [1:0] ACT_UNPIN   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_COUNT  = 2'd2;

  localparam int SLOT_W = 5;
  localparam logic [7:0] CNT_MAX = 8'hFF;

  // one slot entry as held in the slot table
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic        filled;
    logic [31:0] rtime;
  } row_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_get;
    logic in_range;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### hdl/bbc_ctrl.sv
`default_nettype none
module bbc_ctrl
  import bbc_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ISSUE  = 2'd1;
  localparam logic [1:0] S_WAIT   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        priority if (sts.is_get) begin
          cmd.rd   = 1'b1;
          cmd.step = 1'b1;
          if (sts.scan_last) state_nxt = S_WAIT;
        end else if (sts.in_range) begin
          cmd.rd    = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          // bad slot: answer without touching the table
          state_nxt = S_COMMIT;
        end
      end
      S_WAIT: state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/bbc_dp.sv
`default_nettype none
module bbc_dp
  import bbc_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  wire  [1:0]  in_action,
  input  wire  [7:0]  in_device,
  input  wire  [31:0] in_block_number,
  input  wire  [4:0]  in_slot,
  input  wire  [31:0] in_now,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [4:0]  out_result_slot,
  output logic        out_hit,
  output logic        out_needs_fill,
  output logic [1:0]  out_status
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int EXT_W = IDX_W + SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // request word
  logic [1:0]  act_r;
  logic [7:0]  dev_r;
  logic [31:0] blk_r;
  logic [4:0]  slot_r;
  logic [31:0] now_r;

  // slot table
  row_t mem [SLOT_COUNT];
  row_t rd_row_r;
  logic [SLOT_COUNT-1:0] use_r;
  logic [SLOT_COUNT-1:0] mvld_r;

  logic [IDX_W-1:0] ctr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] slot_idx;
  logic [EXT_W-1:0] slot_ext;

  // scan trackers
  logic             hit_f_r, free_f_r, old_f_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, old_idx_r;
  logic [7:0]       hit_cnt_r;
  logic             hit_fill_r;
  logic [31:0]      hit_time_r, free_time_r, old_time_r;

  // table entry as seen through its valid bit
  logic [7:0]  cur_cnt;
  logic        cur_fill;
  logic [31:0] cur_time;
  logic        cur_use;
  logic        cur_match;

  // commit results
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  row_t             wr_row;
  logic             set_use;
  logic [IDX_W-1:0] res_idx;
  logic [EXT_W-1:0] res_ext;
  logic [4:0]       res_slot;
  logic             res_hit, res_fill;
  logic [1:0]       res_st;

  logic out_valid_r;
  logic [4:0] out_slot_r;
  logic out_hit_r, out_fill_r;
  logic [1:0] out_st_r;

  assign slot_ext = EXT_W'(slot_r);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign rd_addr  = (act_r == ACT_GET) ? ctr_r : slot_idx;

  assign sts.is_get    = (act_r == ACT_GET);
  assign sts.in_range  = (32'(slot_r) < SLOT_COUNT);
  assign sts.scan_last = (ctr_r == LAST_IDX);
  assign sts.out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      dev_r  <= in_device;
      blk_r  <= in_block_number;
      slot_r <= in_slot;
      now_r  <= in_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_row_r <= mem[rd_addr];
    if (wr_en)  mem[wr_idx] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r    <= '0;
      mvld_r   <= '0;
      rd_vld_r <= 1'b0;
      ctr_r    <= '0;
    end else begin
      rd_vld_r <= cmd.rd;
      if (cmd.load)      ctr_r <= '0;
      else if (cmd.step) ctr_r <= ctr_r + 1'b1;
      if (wr_en) mvld_r[wr_idx] <= 1'b1;
      if (wr_en && set_use) use_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_idx_r <= rd_addr;
  end

  always_comb begin
    cur_cnt   = mvld_r[rd_idx_r] ? rd_row_r.cnt    : 8'd0;
    cur_fill  = mvld_r[rd_idx_r] ? rd_row_r.filled : 1'b0;
    cur_time  = mvld_r[rd_idx_r] ? rd_row_r.rtime  : 32'd0;
    cur_use   = use_r[rd_idx_r];
    cur_match = cur_use && (rd_row_r.dev == dev_r) && (rd_row_r.blk == blk_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_f_r  <= 1'b0;
      free_f_r <= 1'b0;
      old_f_r  <= 1'b0;
    end else if (rd_vld_r && (act_r == ACT_GET)) begin
      if (cur_match && !hit_f_r) begin
        hit_f_r    <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_cnt_r  <= cur_cnt;
        hit_fill_r <= cur_fill;
        hit_time_r <= cur_time;
      end
      if (!cur_use && !free_f_r) begin
        free_f_r    <= 1'b1;
        free_idx_r  <= rd_idx_r;
        free_time_r <= cur_time;
      end
      // strict compare keeps the lowest index on equal times
      if (cur_use && (cur_cnt == 8'd0) && (!old_f_r || (cur_time < old_time_r))) begin
        old_f_r    <= 1'b1;
        old_idx_r  <= rd_idx_r;
        old_time_r <= cur_time;
      end
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = slot_idx;
    wr_row   = rd_row_r;
    set_use  = 1'b0;
    res_idx  = slot_idx;
    res_hit  = 1'b0;
    res_fill = 1'b0;
    res_st   = ST_OK;
    wr_row.cnt    = cur_cnt;
    wr_row.filled = cur_fill;
    wr_row.rtime  = cur_time;
    priority if (act_r == ACT_GET) begin
      wr_row.dev    = dev_r;
      wr_row.blk    = blk_r;
      wr_row.filled = 1'b1;
      priority if (hit_f_r) begin
        res_idx = hit_idx_r;
        wr_idx  = hit_idx_r;
        res_hit = 1'b1;
        if (hit_cnt_r == CNT_MAX) begin
          res_st = ST_COUNT;
        end else begin
          wr_en        = 1'b1;
          wr_row.cnt   = hit_cnt_r + 8'd1;
          wr_row.rtime = hit_time_r;
          res_fill     = !hit_fill_r;
        end
      end else if (free_f_r || old_f_r) begin
        res_idx      = free_f_r ? free_idx_r : old_idx_r;
        wr_idx       = res_idx;
        wr_en        = 1'b1;
        set_use      = 1'b1;
        wr_row.cnt   = 8'd1;
        wr_row.rtime = free_f_r ? free_time_r : old_time_r;
        res_fill     = 1'b1;
      end else begin
        res_idx = '0;
        res_st  = ST_NOFREE;
      end
    end else if (!sts.in_range) begin
      res_st = ST_NOFREE;
    end else if (act_r == ACT_PIN) begin
      if (cur_cnt == CNT_MAX) begin
        res_st = ST_COUNT;
      end else begin
        wr_en      = 1'b1;
        wr_row.cnt = cur_cnt + 8'd1;
      end
    end else begin
      if (cur_cnt == 8'd0) begin
        res_st = ST_COUNT;
      end else begin
        wr_en      = 1'b1;
        wr_row.cnt = cur_cnt - 8'd1;
        // stamp the time when a release drops the last reference
        if ((act_r == ACT_RELEASE) && (cur_cnt == 8'd1)) wr_row.rtime = now_r;
      end
    end
    wr_en = wr_en && cmd.commit;
  end

  assign res_ext  = EXT_W'(res_idx);
  // out-of-range requests echo the requested slot unchanged
  assign res_slot = (act_r != ACT_GET && !sts.in_range) ? slot_r : res_ext[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot_r <= res_slot;
      out_hit_r  <= res_hit;
      out_fill_r <= res_fill;
      out_st_r   <= res_st;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_hit         = out_hit_r;
  assign out_needs_fill  = out_fill_r;
  assign out_status      = out_st_r;

endmodule
`default_nettype wire

### hdl/block_buffer_cache_lru.sv
`default_nettype none
// Buffer slot manager with least-recently-released replacement. Each request
// word carries an action: get looks up a device/block tag across all slots and
// either raises the count on a hit or claims a victim (first never-used slot,
// else the unreferenced slot with the oldest release time, lowest index on
// ties); release, pin and unpin adjust one slot's reference count. One request
// is in work at a time. A get walks every entry through the slot table's single
// read port, one entry per cycle; release, pin and unpin read only the named
// slot, and one whose slot index is out of range is answered without touching
// the table. The result sits in an output register, so the next request
// is taken while a finished result still waits. No clearing pass after reset.
module block_buffer_cache_lru
  import bbc_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_action,
  input  wire  [7:0]  in_device,
  input  wire  [31:0] in_block_number,
  input  wire  [4:0]  in_slot,
  input  wire  [31:0] in_now,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [4:0]  out_result_slot,
  output logic        out_hit,
  output logic        out_needs_fill,
  output logic [1:0]  out_status
);

  cmd_t cmd;
  sts_t sts;

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbc_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_slot         (in_slot),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_slot (out_result_slot),
    .out_hit         (out_hit),
    .out_needs_fill  (out_needs_fill),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

### test/tb_block_buffer_cache_lru.sv
`timescale 1ns / 1ps
module tb_block_buffer_cache_lru
  import bbc_pkg::*;
;

  localparam int SLOTS       = 32;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int POOL_SIZE   = 40;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       fill;
    logic [1:0] status;
  } slot_answer_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action       = ACT_GET;
  logic [7:0]  in_device       = '0;
  logic [31:0] in_block_number = '0;
  logic [4:0]  in_slot         = '0;
  logic [31:0] in_now          = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [4:0]  out_result_slot;
  logic        out_hit;
  logic        out_needs_fill;
  logic [1:0]  out_status;

  // shadow copy of the slot table
  bit [7:0]  shadow_dev    [SLOTS];
  bit [31:0] shadow_blk    [SLOTS];
  bit        shadow_used   [SLOTS];
  bit [7:0]  shadow_refs   [SLOTS];
  bit        shadow_filled [SLOTS];
  bit [31:0] shadow_stamp  [SLOTS];

  slot_answer_t expected_answers[$];
  int           send_gap_pct;
  int           stall_pct;
  int           fail_count;
  int           cycle_count;
  logic [31:0]  tick      = '0;
  logic [31:0]  fresh_blk = 32'h5A00_0000;

  block_buffer_cache_lru #(
    .SLOT_COUNT(SLOTS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_device       (in_device),
    .in_block_number (in_block_number),
    .in_slot         (in_slot),
    .in_now          (in_now),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_slot (out_result_slot),
    .out_hit         (out_hit),
    .out_needs_fill  (out_needs_fill),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic slot_answer_t cache_predict(input logic [1:0] act,
                                                 input logic [7:0] dev,
                                                 input logic [31:0] blk,
                                                 input logic [4:0] slot,
                                                 input logic [31:0] now);
    slot_answer_t ans;
    bit           found;
    int           victim;
    bit [31:0]    oldest;
    ans    = '0;
    found  = 1'b0;
    victim = 0;
    oldest = '0;
    if (act == ACT_GET) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_used[i] && shadow_dev[i] == dev && shadow_blk[i] == blk) begin
          ans.slot = 5'(i);
          ans.hit  = 1'b1;
          if (shadow_refs[i] == CNT_MAX) begin
            ans.status = ST_COUNT;
          end else begin
            shadow_refs[i]++;
            ans.fill         = !shadow_filled[i];
            shadow_filled[i] = 1'b1;
          end
          return ans;
        end
      end
      // first never-used slot wins, else oldest unreferenced, lowest index on ties
      for (int i = 0; i < SLOTS; i++) begin
        if (!shadow_used[i]) begin
          found  = 1'b1;
          victim = i;
          break;
        end
        if (shadow_refs[i] == 0 && (!found || shadow_stamp[i] < oldest)) begin
          found  = 1'b1;
          victim = i;
          oldest = shadow_stamp[i];
        end
      end
      if (!found) begin
        ans.status = ST_NOFREE;
        return ans;
      end
      shadow_dev[victim]    = dev;
      shadow_blk[victim]    = blk;
      shadow_used[victim]   = 1'b1;
      shadow_refs[victim]   = 8'd1;
      shadow_filled[victim] = 1'b1;
      ans.slot = 5'(victim);
      ans.fill = 1'b1;
      return ans;
    end
    ans.slot = slot;
    if (int'(slot) >= SLOTS) begin
      ans.status = ST_NOFREE;
    end else if (act == ACT_PIN) begin
      if (shadow_refs[slot] == CNT_MAX) ans.status = ST_COUNT;
      else shadow_refs[slot]++;
    end else if (shadow_refs[slot] == 0) begin
      ans.status = ST_COUNT;
    end else begin
      shadow_refs[slot]--;
      if (act == ACT_RELEASE && shadow_refs[slot] == 0) shadow_stamp[slot] = now;
    end
    return ans;
  endfunction

  function automatic logic [31:0] next_tick();
    tick += $urandom_range(1, 500);
    return tick;
  endfunction

  function automatic int free_slot_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!shadow_used[i] || shadow_refs[i] == 0) n++;
    end
    return n;
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [7:0] dev,
                           input logic [31:0] blk, input logic [4:0] slot,
                           input logic [31:0] now);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_device       <= dev;
    in_block_number <= blk;
    in_slot         <= slot;
    in_now          <= now;
    do @(posedge clk); while (in_stall);
    expected_answers.push_back(cache_predict(act, dev, blk, slot, now));
  endtask

  task automatic send_fresh_get();
    send_word(ACT_GET, 8'($urandom), fresh_blk, 5'($urandom), $urandom);
    fresh_blk++;
  endtask

  // drop every reference; tie_stamps packs the release times into a few values
  task automatic release_all(input bit tie_stamps);
    for (int i = 0; i < SLOTS; i++) begin
      while (shadow_refs[i] != 0) begin
        send_word(ACT_RELEASE, 8'($urandom), $urandom, 5'(i),
                  tie_stamps ? 32'($urandom_range(0, 3)) : next_tick());
      end
    end
  endtask

  task automatic test_directed_cases();
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd5, 32'd123);
    send_word(ACT_UNPIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_word(ACT_PIN, 8'h00, 32'h0, 5'd0, 32'h0);
    send_word(ACT_UNPIN, 8'h00, 32'h0, 5'd0, 32'h0);
    send_word(ACT_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0);
    send_word(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_word(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0);
    send_word(ACT_GET, 8'h00, 32'hFFFF_FFFF, 5'd0, 32'h0);
    send_word(ACT_GET, 8'hFF, 32'h0000_0000, 5'd0, 32'h0);
    send_word(ACT_PIN, 8'h00, 32'h0, 5'd1, 32'h0);
    send_word(ACT_UNPIN, 8'h00, 32'h0, 5'd1, 32'h0);
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd1, 32'h0);
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd1, 32'hFFFF_FFFF);
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd1, 32'd5);
    send_word(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0);
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd1, 32'h8000_0000);
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd0, 32'h0);
    send_word(ACT_PIN, 8'h00, 32'h0, 5'd31, 32'h0);
    send_word(ACT_RELEASE, 8'h00, 32'h0, 5'd31, 32'd1);
    send_word(ACT_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0);
    send_word(ACT_GET, 8'hA5, 32'h5A5A_5A5A, 5'd0, 32'h0);
  endtask

  task automatic test_no_free_buffer();
    while (free_slot_count() != 0) send_fresh_get();
    send_fresh_get();
    // all-ones release time must still be eligible
    while (shadow_refs[9] != 0) send_word(ACT_RELEASE, 8'($urandom), $urandom, 5'd9, '1);
    send_fresh_get();
    send_fresh_get();
    release_all(1'b1);
    repeat (4) send_fresh_get();
    release_all(1'b0);
    repeat (3) send_fresh_get();
  endtask

  task automatic test_count_limits();
    logic [7:0]  dev;
    logic [31:0] blk;
    int          target;
    release_all(1'b0);
    dev    = 8'($urandom);
    blk    = fresh_blk;
    target = 0;
    send_word(ACT_GET, dev, blk, 5'($urandom), $urandom);
    fresh_blk++;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_used[i] && shadow_dev[i] == dev && shadow_blk[i] == blk) target = i;
    end
    while (shadow_refs[target] != CNT_MAX) begin
      send_word(ACT_PIN, 8'($urandom), $urandom, 5'(target), $urandom);
    end
    send_word(ACT_PIN, 8'($urandom), $urandom, 5'(target), $urandom);
    send_word(ACT_GET, dev, blk, 5'($urandom), $urandom);
    send_word(ACT_RELEASE, 8'($urandom), $urandom, 5'(target), next_tick());
    send_word(ACT_GET, dev, blk, 5'($urandom), $urandom);
    while (shadow_refs[target] != 0) begin
      send_word($urandom_range(1) ? ACT_RELEASE : ACT_UNPIN, 8'($urandom), $urandom,
                5'(target), next_tick());
    end
    send_word(ACT_UNPIN, 8'($urandom), $urandom, 5'(target), $urandom);
  endtask

  task automatic test_random_traffic(input int count);
    logic [7:0]  pool_dev [POOL_SIZE];
    logic [31:0] pool_blk [POOL_SIZE];
    int          pick;
    int          k;
    int          s;
    logic [1:0]  act;
    logic [31:0] stamp;
    // half the pool shares one device so tags differ only in the block number
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_dev[i] = (i < POOL_SIZE / 2) ? 8'h00 : 8'($urandom);
      pool_blk[i] = (i % 2) ? 32'(i) : $urandom;
    end
    for (int n = 0; n < count; n++) begin
      pick  = $urandom_range(99);
      k     = $urandom_range(POOL_SIZE - 1);
      s     = $urandom_range(SLOTS - 1);
      stamp = ($urandom_range(19) == 0) ? $urandom : next_tick();
      if (pick < 42) begin
        if ($urandom_range(9) == 0) begin
          send_word(ACT_GET, 8'($urandom), $urandom, 5'($urandom), $urandom);
        end else begin
          send_word(ACT_GET, pool_dev[k], pool_blk[k], 5'($urandom), $urandom);
        end
      end else if (pick < 95) begin
        act = (pick < 78) ? ACT_RELEASE : (pick < 86) ? ACT_PIN : ACT_UNPIN;
        // aim most count changes at referenced slots
        if ($urandom_range(4) != 0) begin
          for (int j = 0; j < SLOTS; j++) begin
            if (shadow_refs[(s + j) % SLOTS] != 0) begin
              s = (s + j) % SLOTS;
              break;
            end
          end
        end
        send_word(act, 8'($urandom), $urandom, 5'(s), stamp);
      end else begin
        send_word(2'($urandom), 8'($urandom), $urandom, 5'($urandom), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    slot_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("result word with none pending: result_slot %0d status %0d",
               out_result_slot, out_status);
        fail_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, out_result_slot);
          fail_count++;
        end
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          fail_count++;
        end
        if (out_needs_fill !== want.fill) begin
          $error("needs_fill: expected %0d, got %0d", want.fill, out_needs_fill);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** block_buffer_cache_lru: FAILED **");
      $finish;
    end
  end

  initial begin
    send_gap_pct = 20;
    stall_pct    = 51;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_no_free_buffer();
    test_random_traffic(120);
    send_gap_pct = 51;
    stall_pct    = 20;
    test_count_limits();
    test_random_traffic(110);
    send_gap_pct = 0;
    stall_pct    = 0;
    test_random_traffic(110);
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && expected_answers.size() == 0) begin
      $display("** block_buffer_cache_lru: PASSED **");
    end else begin
      $display("** block_buffer_cache_lru: FAILED **");
    end
    $finish;
  end

endmodule
